// File: rtl/core/tca_pkg.sv
// package for the traffic cellular automaton: payload structs, register
// indexes, reset values and widths shared by the rtl in rtl/core
// no dependencies
`default_nettype none

package tca_pkg;

	localparam int TCA_MAX_CARS_DEF = 4096;

	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 12;
	localparam int SPEED_W  = 4;
	localparam int POS_W    = 32;
	localparam int CNT_W    = 13;
	localparam int IGAP_W   = 8;
	localparam int CFG_IW   = 3;
	localparam int CFG_DW   = 32;

	localparam logic [MODE_W-1:0] MODE_STEP    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_READ    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	localparam logic [CFG_IW-1:0] REG_MAX_SPEED = 3'd0;
	localparam logic [CFG_IW-1:0] REG_SLOW_PROB = 3'd1;
	localparam logic [CFG_IW-1:0] REG_INIT_GAP  = 3'd2;
	localparam logic [CFG_IW-1:0] REG_CAR_COUNT = 3'd3;
	localparam logic [CFG_IW-1:0] REG_RNG_SEED  = 3'd4;

	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 4'd10;
	localparam logic [SPEED_W-1:0] SLOW_PROB_RST = 4'd5;
	localparam logic [IGAP_W-1:0]  INIT_GAP_RST  = 8'd1;
	localparam int                 CAR_COUNT_RST = 4096;
	localparam logic [POS_W-1:0]   RNG_SEED_RST  = 32'd1;

	localparam logic [POS_W-1:0] LFSR_MASK = 32'h8020_0003;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] car_index;
	} req_t;

	typedef struct packed {
		logic [SPEED_W-1:0] car_speed;
		logic [POS_W-1:0]   car_position;
		logic [POS_W-1:0]   car_gap;
		logic               index_error;
	} rsp_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   gap;
	} car_t;

endpackage

`default_nettype wire

// File: rtl/core/traffic_cellular_automaton.sv
// traffic cellular automaton top level: car memory, step pipeline, layout sweep
// depends on tca_pkg
//
//  channel  | dir | handshake                | payload
//  req      | in  | req_valid / req_stall    | tca_pkg::req_t (mode, car_index)
//  rsp      | out | rsp_valid / rsp_stall    | tca_pkg::rsp_t (speed, position, gap, error)
//  cfg      | in  | cfg_write                | cfg_index, cfg_data
//
// a step reads each car once (count limited to MAX_CARS) plus one flush read, then drains the pipeline
// a read passes through the read and done states, an out-of-range read or unused mode goes straight to done
// a restart runs the layout sweep over all MAX_CARS entries: the sweep writes one entry per cycle
// after reset the same sweep runs over all MAX_CARS entries with no response; req is stalled
// one transaction at a time; the next is taken while a finished response waits on rsp_stall
`default_nettype none

module traffic_cellular_automaton #(
	parameter int MAX_CARS = tca_pkg::TCA_MAX_CARS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire tca_pkg::req_t              req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output tca_pkg::rsp_t                   rsp,
	input  wire logic                       cfg_write,
	input  wire logic [tca_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [tca_pkg::CFG_DW-1:0] cfg_data
);
	import tca_pkg::*;

	localparam int AW = $clog2(MAX_CARS);
	localparam int NW = ($clog2(MAX_CARS + 1) > CNT_W) ? $clog2(MAX_CARS + 1) : CNT_W;
	localparam int RST_N = (CAR_COUNT_RST > MAX_CARS) ? MAX_CARS : CAR_COUNT_RST;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_STEP  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;

	logic [SPEED_W-1:0] max_speed_q;
	logic [SPEED_W-1:0] slow_prob_q;
	logic [IGAP_W-1:0]  init_gap_q;
	logic [CNT_W-1:0]   car_count_q;
	logic [POS_W-1:0]   rng_seed_q;
	logic [POS_W-1:0]   lfsr_q;

	logic [IGAP_W-1:0]  lay_gap_q;
	logic [SPEED_W:0]   lay_lead_gap_q;
	logic [AW-1:0]      lay_lead_idx_q;
	logic               lay_lead_en_q;
	logic               clr_rsp_q;
	logic [AW-1:0]      clr_idx_q;
	logic [POS_W-1:0]   pos_acc_q;

	logic [NW-1:0]      rd_cnt_q;
	rsp_t               res_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	car_t               car_mem [MAX_CARS];
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	car_t               wr_data;

	car_t               mem_rdata_s1;
	logic               v_s1;
	logic               first_s1;
	logic               flush_s1;
	logic [AW-1:0]      addr_s1;
	car_t               prev_q;
	logic [AW-1:0]      prev_addr_q;

	logic               v_s2;
	logic [AW-1:0]      addr_s2;
	logic [SPEED_W-1:0] speed_s2;
	logic [POS_W-1:0]   pos_s2;
	logic [POS_W-1:0]   gap_s2;

	logic               v_s3;
	logic [AW-1:0]      addr_s3;
	logic [SPEED_W-1:0] speed_s3;
	logic [POS_W-1:0]   pos_s3;
	logic [POS_W-1:0]   gap_s3;

	logic [NW-1:0]      n_eff;
	logic [NW-1:0]      n_m1;
	logic               req_take;
	logic               rsp_load;
	logic               clr_last;
	logic               iss_flush;
	logic [AW-1:0]      req_addr;

	logic [SPEED_W-1:0] v_inc;
	logic               gap_small;
	logic               limit;
	logic [SPEED_W-1:0] v_lim;
	logic [POS_W-1:0]   lfsr_nx;
	logic [19:0]        prod;
	logic               draw;
	logic               slow;
	logic [SPEED_W-1:0] v_new;

	assign n_eff = (NW'(car_count_q) > NW'(MAX_CARS)) ? NW'(MAX_CARS) : NW'(car_count_q);
	assign n_m1 = n_eff - NW'(1);
	assign req_take = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign clr_last = (clr_idx_q == AW'(MAX_CARS - 1));
	assign iss_flush = (rd_cnt_q == n_eff);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// index widened then cut to the memory address width
	logic [AW+INDEX_W-1:0] req_idx_ext;
	assign req_idx_ext = {{AW{1'b0}}, req.car_index};
	assign req_addr = req_idx_ext[AW-1:0];

	assign rd_addr = (state_q == ST_IDLE) ? req_addr : rd_cnt_q[AW-1:0];

	// layout sweep and step pipeline never write in the same cycle
	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_s3;
		wr_data.speed = speed_s3;
		wr_data.position = pos_s3 + POS_W'(speed_s3);
		wr_data.gap = gap_s3;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = clr_idx_q;
			wr_data.speed = '0;
			wr_data.position = pos_acc_q;
			if (lay_lead_en_q && (clr_idx_q == lay_lead_idx_q)) begin
				wr_data.gap = POS_W'(lay_lead_gap_q);
			end else begin
				wr_data.gap = POS_W'(lay_gap_q);
			end
		end else if (v_s3) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			car_mem[wr_addr] <= wr_data;
		end
		mem_rdata_s1 <= car_mem[rd_addr];
	end

	// per-car speed update
	always_comb begin
		v_inc = (speed_s2 < max_speed_q) ? speed_s2 + SPEED_W'(1) : speed_s2;
		gap_small = (gap_s2[POS_W-1:SPEED_W] == '0);
		limit = gap_small && (v_inc >= gap_s2[SPEED_W-1:0]);
		if (!limit) begin
			v_lim = v_inc;
		end else if (gap_s2[SPEED_W-1:0] == '0) begin
			v_lim = '0;
		end else begin
			v_lim = gap_s2[SPEED_W-1:0] - SPEED_W'(1);
		end
		lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_MASK : '0);
		prod = 20'(lfsr_nx[15:0]) * 20'd10;
		draw = (v_lim != '0);
		slow = draw && (prod[19:16] < slow_prob_q);
		v_new = slow ? v_lim - SPEED_W'(1) : v_lim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= MAX_SPEED_RST;
			slow_prob_q <= SLOW_PROB_RST;
			init_gap_q <= INIT_GAP_RST;
			car_count_q <= CNT_W'(CAR_COUNT_RST);
			rng_seed_q <= RNG_SEED_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MAX_SPEED: max_speed_q <= cfg_data[SPEED_W-1:0];
				REG_SLOW_PROB: slow_prob_q <= cfg_data[SPEED_W-1:0];
				REG_INIT_GAP:  init_gap_q <= cfg_data[IGAP_W-1:0];
				REG_CAR_COUNT: car_count_q <= cfg_data[CNT_W-1:0];
				REG_RNG_SEED:  rng_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			lfsr_q <= RNG_SEED_RST;
			lay_gap_q <= INIT_GAP_RST;
			lay_lead_gap_q <= {1'b0, MAX_SPEED_RST} + (SPEED_W+1)'(1);
			lay_lead_idx_q <= AW'(RST_N - 1);
			lay_lead_en_q <= 1'b1;
			clr_rsp_q <= 1'b0;
			clr_idx_q <= '0;
			pos_acc_q <= '0;
			rd_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_STEP);
			v_s2 <= v_s1 && !first_s1;
			v_s3 <= v_s2;
			if (v_s2 && draw) begin
				lfsr_q <= lfsr_nx;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					pos_acc_q <= pos_acc_q + POS_W'(lay_gap_q);
					if (clr_last) begin
						state_q <= clr_rsp_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						unique case (req.mode)
							MODE_STEP: begin
								rd_cnt_q <= '0;
								state_q <= (n_eff == '0) ? ST_DONE : ST_STEP;
							end
							MODE_READ: begin
								state_q <= (NW'(req.car_index) >= n_eff) ? ST_DONE : ST_READ;
							end
							MODE_RESTART: begin
								lfsr_q <= rng_seed_q;
								lay_gap_q <= init_gap_q;
								lay_lead_gap_q <= {1'b0, max_speed_q} + (SPEED_W+1)'(1);
								lay_lead_idx_q <= n_m1[AW-1:0];
								lay_lead_en_q <= (n_eff != '0);
								clr_rsp_q <= 1'b1;
								clr_idx_q <= '0;
								pos_acc_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_STEP: begin
					if (iss_flush) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_cnt_q <= rd_cnt_q + NW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		first_s1 <= (rd_cnt_q == '0);
		flush_s1 <= iss_flush;
		addr_s1 <= rd_cnt_q[AW-1:0];
		if (v_s1 && !flush_s1) begin
			prev_q <= mem_rdata_s1;
			prev_addr_q <= addr_s1;
		end
		addr_s2 <= prev_addr_q;
		speed_s2 <= prev_q.speed;
		pos_s2 <= prev_q.position;
		gap_s2 <= flush_s1 ? prev_q.gap : mem_rdata_s1.position - prev_q.position;
		addr_s3 <= addr_s2;
		speed_s3 <= v_new;
		pos_s3 <= pos_s2;
		gap_s3 <= gap_s2;
		if (state_q == ST_IDLE && req_take) begin
			res_q <= '{car_speed: '0, car_position: '0, car_gap: '0,
				index_error: (req.mode == MODE_READ) && (NW'(req.car_index) >= n_eff)};
		end else if (state_q == ST_READ) begin
			res_q.car_speed <= mem_rdata_s1.speed;
			res_q.car_position <= mem_rdata_s1.position;
			res_q.car_gap <= mem_rdata_s1.gap;
			res_q.index_error <= 1'b0;
		end else if (state_q == ST_CLEAR || state_q == ST_DRAIN) begin
			res_q <= '0;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

`ifndef ASSERT_OFF
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && !v_s2 && !v_s3)
		else $error("step pipeline not empty while idle");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_CLEAR && v_s3))
		else $error("layout sweep and step pipeline write together");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("response raised outside done state");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.index_error |-> rsp.car_speed == '0 && rsp.car_position == '0
			&& rsp.car_gap == '0)
		else $error("index error transaction carries car data");
`endif

endmodule

`default_nettype wire
